FILE: hdl/tklp_pkg.sv
// Shared types, constants and field tables for the telemetry line parser.
package tklp_pkg;

  localparam int MANT_W      = 40;
  localparam int CALL_W      = 56;
  localparam int FIELD_W     = 5;
  localparam int FRAC_W      = 4;
  localparam int EXP_W       = 5;
  localparam int FRAC_LIMIT  = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // ASCII characters the parser reacts to
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic KIND_FIELD = 1'b0;
  localparam logic KIND_EOL   = 1'b1;

  localparam logic [FIELD_W-1:0] FLD_PACKET = 5'd0;
  localparam logic [FIELD_W-1:0] FLD_TIME   = 5'd1;
  localparam logic [FIELD_W-1:0] FLD_VBAT   = 5'd2;
  localparam logic [FIELD_W-1:0] FLD_ALT    = 5'd3;
  localparam logic [FIELD_W-1:0] FLD_PRS    = 5'd4;
  localparam logic [FIELD_W-1:0] FLD_T1     = 5'd5;
  localparam logic [FIELD_W-1:0] FLD_T2     = 5'd6;
  localparam logic [FIELD_W-1:0] FLD_FLAGS  = 5'd7;
  localparam logic [FIELD_W-1:0] FLD_ACC_X  = 5'd8;
  localparam logic [FIELD_W-1:0] FLD_ACC_Y  = 5'd9;
  localparam logic [FIELD_W-1:0] FLD_ACC_Z  = 5'd10;
  localparam logic [FIELD_W-1:0] FLD_PITCH  = 5'd11;
  localparam logic [FIELD_W-1:0] FLD_YAW    = 5'd12;
  localparam logic [FIELD_W-1:0] FLD_ROLL   = 5'd13;
  localparam logic [FIELD_W-1:0] FLD_SATS   = 5'd14;
  localparam logic [FIELD_W-1:0] FLD_LAT    = 5'd15;
  localparam logic [FIELD_W-1:0] FLD_LON    = 5'd16;
  localparam logic [FIELD_W-1:0] FLD_NONE   = 5'd31;

  typedef enum logic [1:0] {
    REC_UNKNOWN = 2'd0,
    REC_MAIN    = 2'd1,
    REC_ORIENT  = 2'd2,
    REC_GPS     = 2'd3
  } rec_type_e;

  typedef enum logic [1:0] {
    TOK_OPEN,   // recognized key, start a value
    TOK_CHAR,   // one character of an open value
    TOK_CLOSE,  // ';' ends the open value
    TOK_EOL     // newline
  } tok_op_e;

  typedef struct packed {
    tok_op_e              op;
    logic [7:0]           ch;
    logic [FIELD_W-1:0]   field;
    rec_type_e            rec;
    logic                 damaged;
    logic [CALL_W-1:0]    callsign;
  } token_t;

  // decimal scaling of each field
  function automatic logic [1:0] field_scale(input logic [FIELD_W-1:0] f);
    logic [1:0] s;
    s = 2'd0;
    unique case (f) inside
      FLD_VBAT: s = 2'd2;
      FLD_PRS:  s = 2'd3;
      FLD_ALT, FLD_T1, FLD_T2, FLD_ACC_X, FLD_ACC_Y, FLD_ACC_Z,
      FLD_PITCH, FLD_YAW, FLD_ROLL: s = 2'd1;
      default:  s = 2'd0;
    endcase
    return s;
  endfunction

  // fields that take no decimal point
  function automatic logic field_integer(input logic [FIELD_W-1:0] f);
    logic r;
    r = 1'b0;
    unique case (f) inside
      FLD_PACKET, FLD_TIME, FLD_FLAGS, FLD_SATS: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/tklp_front.sv
// Front end: line position, callsign, record type, key match and tokenizing.
module tklp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            q_full_i,
  output logic            push_o,
  output tklp_pkg::token_t token_o
);
  import tklp_pkg::*;

  localparam logic [47:0] TAG_MAIN   = "MAIN:N";
  localparam logic [47:0] TAG_ORIENT = "ORIENT";
  localparam logic [47:0] TAG_GPS    = "GPS:N=";

  function automatic rec_type_e decide_type(input logic [47:0] tc);
    rec_type_e r;
    r = REC_UNKNOWN;
    if (tc == TAG_MAIN) r = REC_MAIN;
    else if (tc == TAG_ORIENT) r = REC_ORIENT;
    else if (tc == TAG_GPS) r = REC_GPS;
    return r;
  endfunction

  // first matching rule wins; c1 is the character just before '='
  function automatic logic [FIELD_W-1:0] match_key(input rec_type_e t, input logic [31:0] w);
    logic [7:0] c1, c2, c3, c4;
    logic [FIELD_W-1:0] f;
    c1 = w[7:0];
    c2 = w[15:8];
    c3 = w[23:16];
    c4 = w[31:24];
    f  = FLD_NONE;
    unique case (t)
      REC_MAIN: begin
        if (c1 == "N") f = FLD_PACKET;
        else if (c1 == "T" && c2 == "E") f = FLD_TIME;
        else if (c1 == "T" && c2 == "A" && c3 == "B" && c4 == "V") f = FLD_VBAT;
        else if (c1 == "T" && c2 == "L" && c3 == "A") f = FLD_ALT;
        else if (c1 == "S" && c2 == "R" && c3 == "P") f = FLD_PRS;
        else if (c1 == "1" && c2 == "T") f = FLD_T1;
        else if (c1 == "2" && c2 == "T") f = FLD_T2;
        else if (c1 == "G" && c2 == "L" && c3 == "F") f = FLD_FLAGS;
      end
      REC_ORIENT: begin
        if (c1 == "N") f = FLD_PACKET;
        else if (c1 == "T" && c2 == "E") f = FLD_TIME;
        else if (c1 == "X" && c2 == "A") f = FLD_ACC_X;
        else if (c1 == "Y" && c2 == "A") f = FLD_ACC_Y;
        else if (c1 == "Z" && c2 == "A") f = FLD_ACC_Z;
        else if (c1 == "H" && c2 == "C") f = FLD_PITCH;
        else if (c1 == "W" && c2 == "A") f = FLD_YAW;
        else if (c1 == "L" && c2 == "L") f = FLD_ROLL;
      end
      REC_GPS: begin
        if (c1 == "N" && c2 != "O") f = FLD_PACKET;
        else if (c1 == "T" && c2 == "E") f = FLD_TIME;
        else if (c1 == "T" && c2 == "A" && c3 == "S") f = FLD_SATS;
        else if (c1 == "T" && c2 == "A" && c3 == "L") f = FLD_LAT;
        else if (c1 == "N" && c2 == "O" && c3 == "L") f = FLD_LON;
        else if (c1 == "T" && c2 == "L" && c3 == "A") f = FLD_ALT;
      end
      default: f = FLD_NONE;
    endcase
    return f;
  endfunction

  logic [3:0]        pos_q, pos_d;
  logic [CALL_W-1:0] call_q, call_d;
  logic [47:0]       tc_q, tc_d;
  rec_type_e         rec_q, rec_d;
  logic [31:0]       key_q, key_d;
  logic              open_q, open_d;

  logic              accept;
  logic              take;
  logic              tok_valid;
  logic [FIELD_W-1:0] key_field;
  token_t            tok;

  assign accept = in_valid_i & ~q_full_i;
  assign take   = accept & (rx_byte_i != CH_CR);

  always_comb begin
    call_d = call_q;
    for (int k = 0; k < 7; k++) begin
      if (pos_q == 4'(k)) begin
        call_d[8*(6-k) +: 8] = call_q[8*(6-k) +: 8] | rx_byte_i;
      end
    end
    tc_d  = (pos_q >= 4'd8 && pos_q <= 4'd13) ? {tc_q[39:0], rx_byte_i} : tc_q;
    rec_d = (pos_q == 4'd13) ? decide_type(tc_d) : rec_q;
    pos_d = (pos_q != 4'd15) ? pos_q + 4'd1 : pos_q;
    key_d = {key_q[23:0], rx_byte_i};
    open_d = open_q;
    key_field = match_key(rec_d, key_q);

    tok_valid     = 1'b0;
    tok.op        = TOK_CHAR;
    tok.ch        = rx_byte_i;
    tok.field     = key_field;
    tok.rec       = rec_d;
    tok.damaged   = 1'b0;
    tok.callsign  = call_d;

    if (rx_byte_i == CH_LF) begin
      // end of line: report what the line had, then start afresh
      tok_valid    = 1'b1;
      tok.op       = TOK_EOL;
      tok.rec      = rec_q;
      tok.callsign = call_q;
      tok.damaged  = open_q;
      call_d = '0;
      tc_d   = '0;
      rec_d  = REC_UNKNOWN;
      pos_d  = 4'd0;
      key_d  = '0;
      open_d = 1'b0;
    end else if (open_q) begin
      tok_valid = 1'b1;
      if (rx_byte_i == CH_SEMI) begin
        tok.op = TOK_CLOSE;
        open_d = 1'b0;
      end
    end else if (rx_byte_i == CH_EQ && key_field != FLD_NONE) begin
      tok_valid = 1'b1;
      tok.op    = TOK_OPEN;
      open_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      call_q <= '0;
      tc_q   <= '0;
      rec_q  <= REC_UNKNOWN;
      key_q  <= '0;
      open_q <= 1'b0;
    end else if (take) begin
      pos_q  <= pos_d;
      call_q <= call_d;
      tc_q   <= tc_d;
      rec_q  <= rec_d;
      key_q  <= key_d;
      open_q <= open_d;
    end
  end

  assign push_o  = take & tok_valid;
  assign token_o = tok;

endmodule

FILE: hdl/tklp_queue.sv
// Short token queue between the front end and the value engine.
module tklp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tklp_pkg::token_t token_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             full_o,
  output tklp_pkg::token_t token_o
);
  import tklp_pkg::*;

  token_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign token_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

FILE: hdl/tklp_back.sv
// Value engine: digit accumulation, saturation, exponent and result register.
module tklp_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              tok_valid_i,
  input  tklp_pkg::token_t                  token_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              result_kind_o,
  output logic [1:0]                        record_type_o,
  output logic [tklp_pkg::FIELD_W-1:0]      field_code_o,
  output logic signed [tklp_pkg::MANT_W-1:0] mantissa_o,
  output logic signed [tklp_pkg::EXP_W-1:0]  decimal_exponent_o,
  output logic                              number_bad_o,
  output logic                              line_damaged_o,
  output logic [tklp_pkg::CALL_W-1:0]       callsign_o
);
  import tklp_pkg::*;

  localparam logic [MANT_W-1:0] HALF = {1'b1, {(MANT_W-1){1'b0}}};

  logic [FIELD_W-1:0] field_q, field_d;
  logic [MANT_W-1:0]  acc_q, acc_d;
  logic               neg_q, neg_d;
  logic [FRAC_W-1:0]  frac_q, frac_d;
  logic               point_q, point_d;
  logic               bad_q, bad_d;
  logic               any_q, any_d;
  logic               digit_q, digit_d;
  logic               sat_q, sat_d;

  logic               emits;
  logic               load;
  logic               is_digit;
  logic [MANT_W-1:0]  lim;
  logic [MANT_W+3:0]  ext, cand;
  logic               over;
  logic               bad_char;
  logic [EXP_W-1:0]   exp_sum;

  logic               out_valid_q;
  logic               kind_q;
  logic [1:0]         rec_q;
  logic [FIELD_W-1:0] fld_out_q;
  logic [MANT_W-1:0]  mant_q;
  logic [EXP_W-1:0]   exp_q;
  logic               nbad_q;
  logic               dmg_q;
  logic [CALL_W-1:0]  call_q;

  assign emits = (token_i.op == TOK_CLOSE) || (token_i.op == TOK_EOL);
  assign pop_o = tok_valid_i & (~emits | ~out_valid_q | ~out_stall_i);
  assign load  = pop_o & emits;

  assign is_digit = (token_i.ch >= CH_ZERO) && (token_i.ch <= CH_NINE);
  assign lim  = HALF - (neg_q ? '0 : MANT_W'(1));
  assign ext  = {4'b0, acc_q};
  // acc * 10 + digit; overflow when it passes the signed limit
  assign cand = (ext << 3) + (ext << 1) + (MANT_W+4)'(token_i.ch[3:0]);
  assign over = cand > {4'b0, lim};

  assign bad_char = bad_q | ~digit_q;
  assign exp_sum  = EXP_W'(frac_q) + EXP_W'(field_scale(field_q));

  always_comb begin
    field_d = field_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    frac_d  = frac_q;
    point_d = point_q;
    bad_d   = bad_q;
    any_d   = any_q;
    digit_d = digit_q;
    sat_d   = sat_q;
    unique case (token_i.op)
      TOK_CHAR: begin
        if ((token_i.ch == CH_PLUS || token_i.ch == CH_MINUS) && !any_q) begin
          neg_d = (token_i.ch == CH_MINUS);
        end else if (is_digit) begin
          digit_d = 1'b1;
          if (!sat_q && (!point_q || frac_q < FRAC_W'(FRAC_LIMIT))) begin
            if (over) begin
              acc_d = lim;
              sat_d = 1'b1;
            end else begin
              acc_d = cand[MANT_W-1:0];
              if (point_q) frac_d = frac_q + 1'b1;
            end
          end
        end else if (token_i.ch == CH_POINT && !point_q && !field_integer(field_q)) begin
          point_d = 1'b1;
        end else begin
          bad_d = 1'b1;
        end
        any_d = 1'b1;
      end
      default: begin
        // open, close and end of line all start from a clean value
        field_d = (token_i.op == TOK_OPEN) ? token_i.field : '0;
        acc_d   = '0;
        neg_d   = 1'b0;
        frac_d  = '0;
        point_d = 1'b0;
        bad_d   = 1'b0;
        any_d   = 1'b0;
        digit_d = 1'b0;
        sat_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      frac_q  <= '0;
      point_q <= 1'b0;
      bad_q   <= 1'b0;
      any_q   <= 1'b0;
      digit_q <= 1'b0;
      sat_q   <= 1'b0;
    end else if (pop_o) begin
      field_q <= field_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      frac_q  <= frac_d;
      point_q <= point_d;
      bad_q   <= bad_d;
      any_q   <= any_d;
      digit_q <= digit_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q  <= token_i.rec;
      call_q <= token_i.callsign;
      if (token_i.op == TOK_EOL) begin
        kind_q    <= KIND_EOL;
        fld_out_q <= '0;
        mant_q    <= '0;
        exp_q     <= '0;
        nbad_q    <= 1'b0;
        dmg_q     <= token_i.damaged;
      end else begin
        kind_q    <= KIND_FIELD;
        fld_out_q <= field_q;
        mant_q    <= bad_char ? '0 : (neg_q ? ('0 - acc_q) : acc_q);
        exp_q     <= bad_char ? '0 : ('0 - exp_sum);
        nbad_q    <= bad_char | sat_q;
        dmg_q     <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = kind_q;
  assign record_type_o      = rec_q;
  assign field_code_o       = fld_out_q;
  assign mantissa_o         = mant_q;
  assign decimal_exponent_o = exp_q;
  assign number_bad_o       = nbad_q;
  assign line_damaged_o     = dmg_q;
  assign callsign_o         = call_q;

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= HALF)
    else $error("accumulator beyond signed limit");

  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_q <= FRAC_W'(FRAC_LIMIT))
    else $error("fraction digit count beyond limit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && out_valid_q |-> !out_stall_i)
    else $error("result register overwritten while stalled");

  a_eol_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_EOL |-> fld_out_q == '0 && mant_q == '0 && !nbad_q)
    else $error("end-of-line result carries field data");

endmodule

FILE: hdl/telemetry_key_value_line_parser_unit.sv
// Top level of the telemetry key/value line parser.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   rx_byte_i
//   result   out        out_valid_o / out_stall_i result_kind_o, record_type_o,
//                                                 field_code_o, mantissa_o,
//                                                 decimal_exponent_o, number_bad_o,
//                                                 line_damaged_o, callsign_o
//
// One byte is taken every cycle while the token queue has room; the token of
// a closing byte (';' or newline) passes through the queue to the value engine,
// which loads its result into the output register. The value engine retires
// one token a cycle unless a closing token waits on a stalled result: its
// single add-and-compare for acc*10+digit sets that figure. Carriage returns
// and bytes outside a value that open nothing leave no token for the queue.
// Reset clears line state, the queue and the output valid at once; there is
// no clearing pass. A stalled result holds the output register; tokens that
// need no result keep draining meanwhile, and the input stalls only when the
// queue fills.
module telemetry_key_value_line_parser_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         rx_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               result_kind_o,
  output logic [1:0]                         record_type_o,
  output logic [tklp_pkg::FIELD_W-1:0]       field_code_o,
  output logic signed [tklp_pkg::MANT_W-1:0] mantissa_o,
  output logic signed [tklp_pkg::EXP_W-1:0]  decimal_exponent_o,
  output logic                               number_bad_o,
  output logic                               line_damaged_o,
  output logic [tklp_pkg::CALL_W-1:0]        callsign_o
);
  import tklp_pkg::*;

  logic   push;
  logic   pop;
  logic   q_valid;
  logic   q_full;
  token_t front_tok;
  token_t head_tok;

  // Classify each byte into a token: open, value character, close, newline.
  tklp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .rx_byte_i (rx_byte_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .token_o   (front_tok)
  );

  // Decouple the two halves so an output stall does not block the input at once.
  tklp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .token_i(front_tok),
    .pop_i  (pop),
    .valid_o(q_valid),
    .full_o (q_full),
    .token_o(head_tok)
  );

  // Accumulate digits and build field and end-of-line results.
  tklp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .tok_valid_i       (q_valid),
    .token_i           (head_tok),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_kind_o     (result_kind_o),
    .record_type_o     (record_type_o),
    .field_code_o      (field_code_o),
    .mantissa_o        (mantissa_o),
    .decimal_exponent_o(decimal_exponent_o),
    .number_bad_o      (number_bad_o),
    .line_damaged_o    (line_damaged_o),
    .callsign_o        (callsign_o)
  );

  // Hold off the sender only while the queue is full.
  assign in_stall_o = q_full;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the telemetry key/value line parser.
`timescale 1ns / 100ps

module tb;
  import tklp_pkg::*;

  // One expected result beat, in the order of the result channel fields
  typedef struct packed {
    logic               kind;
    rec_type_e          rec;
    logic [FIELD_W-1:0] field;
    logic [MANT_W-1:0]  mant;
    logic [EXP_W-1:0]   expo;
    logic               bad;
    logic               damaged;
    logic [CALL_W-1:0]  call;
  } line_result_t;

  // One byte beat waiting for the driver; drain_first holds it back until
  // every result predicted so far has been checked
  typedef struct packed {
    logic [7:0] ch;
    logic       drain_first;
  } stim_t;

  localparam int LONG_HOLD_AT    = 40;   // result count that starts the long stall
  localparam int LONG_HOLD_LEN   = 150;  // cycles of that stall
  localparam int TOTAL_BYTES     = 1120; // least number of byte beats queued, directed lines included
  localparam int SETTLE_CYCLES   = 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic [7:0]               rx_byte   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_kind;
  logic [1:0]               out_rec;
  logic [FIELD_W-1:0]       out_field;
  logic signed [MANT_W-1:0] out_mant;
  logic signed [EXP_W-1:0]  out_expo;
  logic                     out_bad;
  logic                     out_damaged;
  logic [CALL_W-1:0]        out_call;

  stim_t        stim_q[$];
  line_result_t results_due[$];
  bit           pending_drain = 1'b0;
  string        key_names [19];

  int unsigned n_predicted = 0;  // driver side, blocking
  int unsigned n_checked   = 0;  // monitor side, nonblocking
  int unsigned n_sent      = 0;
  int unsigned n_errors    = 0;
  int          gap_left    = 0;
  int          hold_left   = 0;

  // Line parser state as the predictor sees it
  logic [3:0]        pos_q   = '0;
  logic [CALL_W-1:0] call_q  = '0;
  logic [47:0]       tag_q   = '0;
  rec_type_e         rec_q   = REC_UNKNOWN;
  logic [31:0]       keys_q  = '0;
  bit                val_open, val_neg, val_point, val_bad, val_any, val_digit, val_sat;
  logic [FIELD_W-1:0] val_field;
  logic [63:0]       val_mag;
  int                val_frac;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  telemetry_key_value_line_parser_unit u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .rx_byte_i          (rx_byte),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .result_kind_o      (out_kind),
    .record_type_o      (out_rec),
    .field_code_o       (out_field),
    .mantissa_o         (out_mant),
    .decimal_exponent_o (out_expo),
    .number_bad_o       (out_bad),
    .line_damaged_o     (out_damaged),
    .callsign_o         (out_call)
  );

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Forget the open value and everything gathered for it.
  task automatic drop_value();
    val_open  = 1'b0;
    val_field = '0;
    val_mag   = '0;
    val_neg   = 1'b0;
    val_frac  = 0;
    val_point = 1'b0;
    val_bad   = 1'b0;
    val_any   = 1'b0;
    val_digit = 1'b0;
    val_sat   = 1'b0;
  endtask

  // Append one decimal digit to the magnitude; clamp at the signed limit of
  // the mantissa and stick there once it overflows.
  task automatic push_digit(input logic [63:0] d);
    logic [63:0] ceiling;
    ceiling = (64'd1 << (MANT_W - 1)) - (val_neg ? 64'd0 : 64'd1);
    if (val_mag > (ceiling - d) / 64'd10) begin
      val_mag = ceiling;
      val_sat = 1'b1;
    end else begin
      val_mag = val_mag * 64'd10 + d;
    end
  endtask

  // Advance the line state by one accepted byte and queue the result it causes.
  task automatic parse_byte(input logic [7:0] c);
    line_result_t r;
    logic [7:0]   k1, k2, k3, k4;
    logic [FIELD_W-1:0] f;
    logic [63:0]  m;
    logic         faulty, whole_only;
    int           slot, scale;
    if (c == CH_CR) begin
      // carriage return leaves no trace at all
    end else if (c == CH_LF) begin
      r         = '0;
      r.kind    = KIND_EOL;
      r.rec     = rec_q;
      r.damaged = val_open;
      r.call    = call_q;
      results_due.push_back(r);
      n_predicted++;
      pos_q  = '0;
      call_q = '0;
      tag_q  = '0;
      rec_q  = REC_UNKNOWN;
      keys_q = '0;
      drop_value();
    end else begin
      if (pos_q <= 4'd6) begin
        slot = 6 - int'(pos_q);
        call_q[slot*8 +: 8] = c;
      end
      if (pos_q >= 4'd8 && pos_q <= 4'd13) tag_q = {tag_q[39:0], c};
      // the record type settles on character 13, before it counts as a key
      if (pos_q == 4'd13) begin
        if (tag_q == "MAIN:N")      rec_q = REC_MAIN;
        else if (tag_q == "ORIENT") rec_q = REC_ORIENT;
        else if (tag_q == "GPS:N=") rec_q = REC_GPS;
        else                        rec_q = REC_UNKNOWN;
      end
      if (pos_q < 4'd15) pos_q++;

      if (val_open && c == CH_SEMI) begin
        case (val_field)
          FLD_VBAT: scale = 2;
          FLD_PRS:  scale = 3;
          FLD_ALT, FLD_T1, FLD_T2, FLD_ACC_X, FLD_ACC_Y, FLD_ACC_Z,
          FLD_PITCH, FLD_YAW, FLD_ROLL: scale = 1;
          default:  scale = 0;
        endcase
        faulty  = val_bad || !val_digit;
        r       = '0;
        r.kind  = KIND_FIELD;
        r.rec   = rec_q;
        r.field = val_field;
        if (!faulty) begin
          m      = val_neg ? (64'd0 - val_mag) : val_mag;
          r.mant = m[MANT_W-1:0];
          r.expo = EXP_W'(-(val_frac + scale));
        end
        r.bad  = faulty || val_sat;
        r.call = call_q;
        results_due.push_back(r);
        n_predicted++;
        drop_value();
      end else if (val_open) begin
        whole_only = (val_field == FLD_PACKET || val_field == FLD_TIME ||
                      val_field == FLD_FLAGS  || val_field == FLD_SATS);
        if ((c == CH_MINUS || c == CH_PLUS) && !val_any) begin
          val_neg = (c == CH_MINUS);
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          val_digit = 1'b1;
          if (!val_sat) begin
            if (!val_point) begin
              push_digit(64'(c - CH_ZERO));
            end else if (val_frac < FRAC_LIMIT) begin
              push_digit(64'(c - CH_ZERO));
              if (!val_sat) val_frac++;
            end
          end
        end else if (c == CH_POINT && !val_point && !whole_only) begin
          val_point = 1'b1;
        end else begin
          val_bad = 1'b1;
        end
        val_any = 1'b1;
      end else if (c == CH_EQ) begin
        // look up the key from the last characters, newest in k1
        {k4, k3, k2, k1} = keys_q;
        f = FLD_NONE;
        case (rec_q)
          REC_MAIN: begin
            if (k1 == "N")                                          f = FLD_PACKET;
            else if (k1 == "T" && k2 == "E")                        f = FLD_TIME;
            else if (k1 == "T" && k2 == "A" && k3 == "B" && k4 == "V") f = FLD_VBAT;
            else if (k1 == "T" && k2 == "L" && k3 == "A")           f = FLD_ALT;
            else if (k1 == "S" && k2 == "R" && k3 == "P")           f = FLD_PRS;
            else if (k1 == "1" && k2 == "T")                        f = FLD_T1;
            else if (k1 == "2" && k2 == "T")                        f = FLD_T2;
            else if (k1 == "G" && k2 == "L" && k3 == "F")           f = FLD_FLAGS;
          end
          REC_ORIENT: begin
            if (k1 == "N")                   f = FLD_PACKET;
            else if (k1 == "T" && k2 == "E") f = FLD_TIME;
            else if (k1 == "X" && k2 == "A") f = FLD_ACC_X;
            else if (k1 == "Y" && k2 == "A") f = FLD_ACC_Y;
            else if (k1 == "Z" && k2 == "A") f = FLD_ACC_Z;
            else if (k1 == "H" && k2 == "C") f = FLD_PITCH;
            else if (k1 == "W" && k2 == "A") f = FLD_YAW;
            else if (k1 == "L" && k2 == "L") f = FLD_ROLL;
          end
          REC_GPS: begin
            if (k1 == "N" && k2 != "O")                   f = FLD_PACKET;
            else if (k1 == "T" && k2 == "E")              f = FLD_TIME;
            else if (k1 == "T" && k2 == "A" && k3 == "S") f = FLD_SATS;
            else if (k1 == "T" && k2 == "A" && k3 == "L") f = FLD_LAT;
            else if (k1 == "N" && k2 == "O" && k3 == "L") f = FLD_LON;
            else if (k1 == "T" && k2 == "L" && k3 == "A") f = FLD_ALT;
          end
          default: f = FLD_NONE;
        endcase
        if (f != FLD_NONE) begin
          drop_value();
          val_open  = 1'b1;
          val_field = f;
        end
      end
      keys_q = {keys_q[23:0], c};
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------

  task automatic put_byte(input logic [7:0] b);
    stim_t s;
    s.ch          = b;
    s.drain_first = pending_drain;
    pending_drain = 1'b0;
    stim_q.push_back(s);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_digits(input int n);
    repeat (n) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  // Emit one value: mostly well formed, the rest hits the odd corners.
  task automatic put_value();
    int mode;
    mode = $urandom_range(0, 19);
    case (mode)
      10: put_digits($urandom_range(11, 16));               // saturates often
      11: begin
        put_text("0.");
        put_digits($urandom_range(10, 16));                 // long fraction
      end
      12: ;                                                 // empty value
      13: put_byte(CH_MINUS);                               // sign, no digit
      14: begin
        put_digits(2);
        put_byte(8'($urandom_range(0, 255)));               // any stray byte
        put_digits(1);
      end
      15: begin
        put_digits(1);
        put_text("..");
        put_digits(1);
      end
      16: begin
        put_digits(2);
        put_byte(CH_MINUS);
        put_digits(2);
      end
      17: begin
        put_digits(1);
        put_byte(CH_EQ);
        put_digits(1);
      end
      18: begin
        case ($urandom_range(0, 2))
          0:       put_text("549755813887");
          1:       put_text("-549755813888");
          default: put_text("+549755813888");
        endcase
      end
      19: begin
        put_text("0000000000000");
        put_digits(3);
      end
      default: begin
        if ($urandom_range(0, 2) == 0) put_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        put_digits($urandom_range(1, 6));
        if ($urandom_range(0, 1) == 1) begin
          put_byte(CH_POINT);
          put_digits($urandom_range(1, 4));
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Driver: offer one byte beat at a time, idle between beats at random
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : drive_bytes
    logic  take, nxt_valid, quiet;
    logic [7:0] nxt_byte;
    stim_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      rx_byte  <= '0;
      gap_left = 0;
    end else begin
      take      = in_valid && !in_stall;
      nxt_valid = in_valid;
      nxt_byte  = rx_byte;
      // stretches of back-to-back beats between the idling ones
      quiet     = (n_sent % 96) < 24;
      if (take) begin
        parse_byte(rx_byte);
        n_sent++;
        gap_left = quiet ? 0 : $urandom_range(0, 5);
      end
      // hold a stalled beat; otherwise idle out the gap or load the next one
      if (!in_valid || take) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0 &&
                     (!stim_q[0].drain_first || n_checked == n_predicted)) begin
          nxt       = stim_q.pop_front();
          nxt_valid = 1'b1;
          nxt_byte  = nxt.ch;
        end
      end
      in_valid <= nxt_valid;
      rx_byte  <= nxt_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: take result beats, check each against the oldest expectation
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    n_errors++;
  endtask

  always @(posedge clk or negedge rst_n) begin : check_results
    line_result_t due;
    logic quiet;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      quiet = (n_checked % 40) >= 28;
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result, kind", -1, longint'(out_kind));
        end else begin
          due = results_due.pop_front();
          if (out_kind !== due.kind)       report_mismatch("result_kind", due.kind, out_kind);
          if (out_rec !== due.rec)         report_mismatch("record_type", due.rec, out_rec);
          if (out_field !== due.field)     report_mismatch("field_code", due.field, out_field);
          if (out_mant !== due.mant)
            report_mismatch("mantissa", $signed(due.mant), out_mant);
          if (out_expo !== due.expo)
            report_mismatch("decimal_exponent", $signed(due.expo), out_expo);
          if (out_bad !== due.bad)         report_mismatch("number_bad", due.bad, out_bad);
          if (out_damaged !== due.damaged) report_mismatch("line_damaged", due.damaged, out_damaged);
          if (out_call !== due.call)       report_mismatch("callsign", due.call, out_call);
          n_checked <= n_checked + 1;
        end
        hold_left = quiet ? 0 : $urandom_range(0, 5);
        // one long hold-off so the token queue fills and the input stalls
        if (n_checked == LONG_HOLD_AT) hold_left = LONG_HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------
  initial begin
    int line_form, nfields, k, n_line, stop_at;
    key_names = '{"MET", "VBAT", "ALT", "PRS", "T1", "T2", "FLG", "AX", "AY", "AZ",
                  "PITCH", "YAW", "ROLL", "SAT", "LAT", "LON", "ID", "LN", "TIME"};

    // Directed lines: empty line, short line with extreme bytes, every field
    // of every record type, limits, saturation, long fraction, malformed
    // values, unknown key and a line cut off inside a value.
    put_byte(CH_LF);
    put_text("AB");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_LF);
    pending_drain = 1'b1;
    put_text("CALL001,MAIN:N=42;MET=123456;VBAT=3.71;ALT=-12.5;PRS=101.325;");
    put_text("T1=+21.4;T2=-0.5;FLG=7;");
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_text("CALL002,ORIENT:N=5;AX=1.5;AY=-2;AZ=0.25;PITCH=10;YAW=-180.0;ROLL=45.5;MET=9;");
    put_byte(CH_LF);
    put_text("CALL003,GPS:N=7;SAT=12;LAT=52.123456;LON=-4.5;ALT=300.5;MET=8;");
    put_byte(CH_LF);
    put_text("CALL004,MAIN:N=549755813887;VBAT=-549755813888;ALT=549755813888123;");
    put_text("PRS=0.00000000000012345;MET=1.5;");
    put_byte(CH_LF);
    put_text("CALL005,MAIN:N=;T1=1..2;T2=3a;FLG=-;XYZ=5;ALT=1=2;T1=3-4;T2=--1;ALT=12");
    put_byte(CH_LF);

    // Random lines: mostly well formed records with random content, some
    // unknown or short lines, raw noise and lines cut off mid-value.
    stop_at = TOTAL_BYTES;
    n_line  = 0;
    while (stim_q.size() < stop_at) begin
      n_line++;
      if (n_line % 15 == 7) pending_drain = 1'b1;
      line_form = $urandom_range(0, 9);
      if (line_form == 0) begin
        repeat ($urandom_range(0, 24)) put_byte(8'($urandom_range(0, 255)));
        put_byte(CH_LF);
      end else begin
        repeat (7) put_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(8'h30, 8'h39))
                                                      : 8'($urandom_range(8'h41, 8'h5A)));
        put_byte(",");
        case (line_form)
          1: begin
            case ($urandom_range(0, 2))
              0:       put_text("MAIN:X");
              1:       put_text("ORIENt");
              default: repeat (6) put_byte(8'($urandom_range(8'h20, 8'h7E)));
            endcase
          end
          2, 3:    put_text("MAIN:N=");
          4, 5:    put_text("ORIENT:N=");
          6, 7:    put_text("GPS:N=");
          default: put_text("MAIN=");     // too short to match a known type
        endcase
        put_value();
        put_byte(CH_SEMI);
        nfields = $urandom_range(0, 6);
        repeat (nfields) begin
          if ($urandom_range(0, 6) == 0) begin
            k = $urandom_range(0, 18);
          end else begin
            case (line_form)
              2, 3: k = $urandom_range(0, 6);
              4, 5: begin
                k = $urandom_range(6, 12);
                if (k == 6) k = 0;
              end
              6, 7: begin
                case ($urandom_range(0, 4))
                  0:       k = 0;
                  1:       k = 2;
                  2:       k = 13;
                  3:       k = 14;
                  default: k = 15;
                endcase
              end
              default: k = $urandom_range(0, 18);
            endcase
          end
          if ($urandom_range(0, 9) == 0) put_byte(8'($urandom_range(0, 255)));
          put_text(key_names[k]);
          put_byte(CH_EQ);
          put_value();
          put_byte(CH_SEMI);
        end
        case ($urandom_range(0, 9))
          0: begin
            put_text("ALT=");
            put_digits($urandom_range(0, 3));
          end
          1: put_byte(CH_CR);
          default: ;
        endcase
        put_byte(CH_LF);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last beat to go out and every result to come back,
    // then let the pipeline settle before looking for stray beats.
    while (stim_q.size() != 0 || in_valid || n_checked != n_predicted) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (results_due.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, results_due.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: sim.f
hdl/tklp_pkg.sv
hdl/tklp_front.sv
hdl/tklp_queue.sv
hdl/tklp_back.sv
hdl/telemetry_key_value_line_parser_unit.sv
sim/tb.sv
